/* src/mrob_pkg.sv */
// mrob_pkg: shared types and constants of the overwriting ring buffer
// field widths, operation codes, status codes, controller states, control and status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrob_pkg;

  // fixed payload widths
  localparam int REC_W  = 48;
  localparam int OP_W   = 2;
  localparam int RDR_W  = 2;
  localparam int STAT_W = 2;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_CLAIM   = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SLOT = 2'd2;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_POP_RD
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;        // request accepted, run it this cycle
    logic finish_pop;  // memory read data is ready, load the pop result
  } ctrl_cmd_t;

  // status seen by the controller
  typedef struct packed {
    logic in_valid;
    logic is_pop;
    logic out_busy;    // a result sits in the output register and is not taken
  } ctrl_stat_t;

endpackage

`default_nettype wire

/* src/mrob_ifs.sv */
// mrob_ifs: valid/ready channel interfaces for requests and results
// depends on mrob_pkg for the payload widths
`timescale 1ns / 1ps
`default_nettype none

interface mrob_in_if import mrob_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [RDR_W-1:0] reader;
  logic [REC_W-1:0] element_in;

  modport source (output valid, output opcode, output reader, output element_in,
                  input ready);
  modport sink (input valid, input opcode, input reader, input element_in,
                output ready);
endinterface

interface mrob_out_if import mrob_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REC_W-1:0]  element_out;
  logic [STAT_W-1:0] status;
  logic [RDR_W-1:0]  granted_reader;
  logic              reader_empty;

  modport source (output valid, output element_out, output status,
                  output granted_reader, output reader_empty, input ready);
  modport sink (input valid, input element_out, input status,
                input granted_reader, input reader_empty, output ready);
endinterface

`default_nettype wire

/* src/mrob_ctrl.sv */
// mrob_ctrl: request sequencer of the ring buffer
// push, claim and release finish when accepted; pops wait in ST_POP_RD for the memory read
// depends on mrob_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrob_ctrl import mrob_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ctrl_stat_t stat,
  output logic            in_ready,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.exec       = 1'b0;
    cmd.finish_pop = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !stat.out_busy;
        cmd.exec = stat.in_valid && !stat.out_busy;
        if (cmd.exec && stat.is_pop) begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        cmd.finish_pop = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/mrob_dp.sv */
// mrob_dp: datapath of the ring buffer
// record memory, write index, reader heads, slot flags and output register
// depends on mrob_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrob_dp import mrob_pkg::*; #(
  parameter int DEPTH   = 32,
  parameter int READERS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctrl_cmd_t         cmd,
  input  wire logic [OP_W-1:0]   opcode,
  input  wire logic [RDR_W-1:0]  reader,
  input  wire logic [REC_W-1:0]  element_in,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [REC_W-1:0]       element_out,
  output logic [STAT_W-1:0]      status,
  output logic [RDR_W-1:0]       granted_reader,
  output logic                   reader_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // ring increment, wraps after the last entry
  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == LAST) ? '0 : i + AW'(1);
  endfunction

  // record memory
  logic [REC_W-1:0] mem [DEPTH];
  logic [REC_W-1:0] rd_data_r;

  // control state
  logic [AW-1:0] wi_r, wi_nxt;
  logic [AW-1:0] head_r [READERS];
  logic [AW-1:0] head_nxt [READERS];
  logic [READERS-1:0] taken_r, taken_nxt;

  // pop result waiting for memory data
  logic pop_ok_r, pop_ok_nxt;
  logic pop_empty_r, pop_empty_nxt;

  // output register
  logic              out_valid_r;
  logic [REC_W-1:0]  elem_r;
  logic [STAT_W-1:0] status_r;
  logic [RDR_W-1:0]  grant_r;
  logic              empty_r;

  op_t           op;
  logic          in_rng;
  logic [AW-1:0] sel_head;
  logic          sel_empty;
  logic [AW-1:0] nxt, nnx;
  logic [AW-1:0] pop_head;
  logic          found;
  logic [STAT_W-1:0] res_status;
  logic [RDR_W-1:0]  res_grant;
  logic              res_empty;
  logic              out_load;

  assign op     = op_t'(opcode);
  assign in_rng = int'(reader) < READERS;
  assign nxt    = ring_next(wi_r);
  assign nnx    = ring_next(nxt);

  // addressed reader's head
  always_comb begin
    sel_head = '0;
    for (int i = 0; i < READERS; i++) begin
      if (int'(reader) == i) begin
        sel_head = head_r[i];
      end
    end
  end

  assign sel_empty = !in_rng || (sel_head == wi_r);
  assign pop_head  = ring_next(sel_head);

  // per-request state update and immediate result
  always_comb begin
    wi_nxt        = wi_r;
    taken_nxt     = taken_r;
    pop_ok_nxt    = pop_ok_r;
    pop_empty_nxt = pop_empty_r;
    res_status    = STAT_OK;
    res_grant     = '0;
    res_empty     = sel_empty;
    found         = 1'b0;
    for (int i = 0; i < READERS; i++) begin
      head_nxt[i] = head_r[i];
    end
    if (cmd.exec) begin
      case (op)
        OP_PUSH: begin
          // a head one past the write index loses its oldest record
          for (int i = 0; i < READERS; i++) begin
            if (head_r[i] == nxt) begin
              head_nxt[i] = nnx;
            end
          end
          wi_nxt    = nxt;
          res_empty = !in_rng || (((sel_head == nxt) ? nnx : sel_head) == nxt);
        end
        OP_POP: begin
          pop_ok_nxt    = !sel_empty;
          pop_empty_nxt = sel_empty || (pop_head == wi_r);
          if (!sel_empty) begin
            for (int i = 0; i < READERS; i++) begin
              if (int'(reader) == i) begin
                head_nxt[i] = pop_head;
              end
            end
          end
        end
        OP_CLAIM: begin
          // lowest free slot wins
          res_status = STAT_NO_SLOT;
          for (int i = 0; i < READERS; i++) begin
            if (!found && !taken_r[i]) begin
              found        = 1'b1;
              taken_nxt[i] = 1'b1;
              res_grant    = RDR_W'(i);
              res_status   = STAT_OK;
            end
          end
        end
        OP_RELEASE: begin
          for (int i = 0; i < READERS; i++) begin
            if (int'(reader) == i) begin
              taken_nxt[i] = 1'b0;
            end
          end
        end
        default: begin
          res_status = STAT_OK;
        end
      endcase
    end
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r    <= '0;
      taken_r <= '0;
      for (int i = 0; i < READERS; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      wi_r    <= wi_nxt;
      taken_r <= taken_nxt;
      for (int i = 0; i < READERS; i++) begin
        head_r[i] <= head_nxt[i];
      end
    end
  end

  // pending pop flags
  always_ff @(posedge clk) begin
    pop_ok_r    <= pop_ok_nxt;
    pop_empty_r <= pop_empty_nxt;
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && (op == OP_PUSH)) begin
      mem[wi_r] <= element_in;
    end
    if (cmd.exec && (op == OP_POP)) begin
      rd_data_r <= mem[sel_head];
    end
  end

  // output register
  assign out_load = (cmd.exec && (op != OP_POP)) || cmd.finish_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_pop) begin
      elem_r   <= pop_ok_r ? rd_data_r : '0;
      status_r <= pop_ok_r ? STAT_OK : STAT_EMPTY;
      grant_r  <= '0;
      empty_r  <= pop_empty_r;
    end else if (out_load) begin
      elem_r   <= '0;
      status_r <= res_status;
      grant_r  <= res_grant;
      empty_r  <= res_empty;
    end
  end

  assign out_valid      = out_valid_r;
  assign element_out    = elem_r;
  assign status         = status_r;
  assign granted_reader = grant_r;
  assign reader_empty   = empty_r;

endmodule

`default_nettype wire

/* src/multi_reader_overwrite_ring_buffer.sv */
// Single-writer, multi-reader overwriting ring of 48-bit records. Push, claim
// and release finish when accepted; a pop goes on to the ST_POP_RD state,
// because the record memory has one registered read port and the result is
// loaded once its data returns. One request is in flight at a time, and a new
// request is taken while a result waits in the output register only if that
// result is taken in the same cycle. Usable capacity per reader is DEPTH-1: a
// push moves any head that would look empty one entry on, dropping that
// reader's oldest record. No clearing pass runs after reset; the memory needs none.
// depends on mrob_pkg, mrob_ifs, mrob_ctrl and mrob_dp
`timescale 1ns / 1ps
`default_nettype none

module multi_reader_overwrite_ring_buffer import mrob_pkg::*; #(
  parameter int DEPTH   = 32,
  parameter int READERS = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mrob_in_if.sink    in_ch,
  mrob_out_if.source out_ch
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       out_valid;

  // status for the sequencer
  assign stat.in_valid = in_ch.valid;
  assign stat.is_pop   = (op_t'(in_ch.opcode) == OP_POP);
  assign stat.out_busy = out_valid && !out_ch.ready;

  mrob_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  mrob_dp #(
    .DEPTH   (DEPTH),
    .READERS (READERS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .opcode         (in_ch.opcode),
    .reader         (in_ch.reader),
    .element_in     (in_ch.element_in),
    .out_ready      (out_ch.ready),
    .out_valid      (out_valid),
    .element_out    (out_ch.element_out),
    .status         (out_ch.status),
    .granted_reader (out_ch.granted_reader),
    .reader_empty   (out_ch.reader_empty)
  );

  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
